>>> rtl/core/fsba_pkg.sv
// fsba_pkg: shared types and codes for the fit-strategy block allocator.
// No dependencies.
`default_nettype none

package fsba_pkg;

    localparam int AMOUNT_W = 16;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int STRAT_W  = 2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    localparam logic CFG_STRATEGY    = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/fit_strategy_block_allocator.sv
// fit_strategy_block_allocator: first/best/worst fit allocator over a size table.
// Depends on fsba_pkg and fsba_ram.
//
// channel | dir | handshake                  | payload
// in      | in  | i_in_valid / o_in_ready    | i_opcode i_block_index i_amount i_last_request
// out     | out | o_out_valid / i_out_ready  | o_allocated o_chosen_block o_last_result
// cfg     | in  | i_cfg_wr_en                | i_cfg_index i_cfg_wdata
//
// A load word is written in the cycle it is accepted; the next word may follow at once.
// A request scans limit = min(block_count, BLOCKS) blocks: one RAM read per block and a
// compare of each read result, then it leaves the scan and, in S_FIN, writes back the
// reduced size of the chosen block; under the undefined strategy it goes straight to S_FIN.
// A request holds in its final cycle while the output register is still full.
// Reset (synchronous, active low) clears control state only; the size table is not cleared.
`default_nettype none

module fit_strategy_block_allocator
    import fsba_pkg::*;
#(
    parameter int BLOCKS     = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_opcode,
    input  wire logic [INDEX_W-1:0]  i_block_index,
    input  wire logic [AMOUNT_W-1:0] i_amount,
    input  wire logic                i_last_request,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_allocated,
    output logic [INDEX_W-1:0]       o_chosen_block,
    output logic                     o_last_result,
    input  wire logic                i_cfg_wr_en,
    input  wire logic                i_cfg_index,
    input  wire logic [COUNT_W-1:0]  i_cfg_wdata
);

    localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW = $clog2(BLOCKS + 1);
    localparam logic [CW-1:0] BLOCKS_C = CW'(BLOCKS);

    t_state                r_state;
    logic [STRAT_W-1:0]    r_strategy;
    logic [COUNT_W-1:0]    r_block_count;
    logic [CW-1:0]         r_issue_cnt;
    logic                  r_pend;
    logic [IW-1:0]         r_pend_idx;
    logic                  r_found;
    logic [IW-1:0]         r_best_idx;
    logic [SIZE_WIDTH-1:0] r_best_sz;
    logic [AMOUNT_W-1:0]   r_need;
    logic                  r_last;
    logic                  r_out_valid;
    logic                  r_alloc;
    logic [INDEX_W-1:0]    r_chosen;
    logic                  r_out_last;

    logic [CW-1:0]         limit;
    logic                  in_acc;
    logic                  out_free;
    logic                  fits;
    logic                  take;
    logic [31:0]           in_idx32;
    logic [31:0]           best_idx32;
    logic [47:0]           amt48;
    logic [SIZE_WIDTH-1:0] rd_data;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;
    logic [IW-1:0]         rd_addr;

    assign limit = (32'(r_block_count) > BLOCKS) ? BLOCKS_C : CW'(r_block_count);
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign in_idx32 = 32'(i_block_index);
    assign best_idx32 = 32'(r_best_idx);
    assign amt48 = 48'(i_amount);

    assign fits = 33'(rd_data) >= 33'(r_need);

    always_comb begin
        take = 1'b0;
        if (r_pend && fits) begin
            case (r_strategy)
                STRAT_FIRST: take = !r_found;
                STRAT_BEST:  take = !r_found || (rd_data < r_best_sz);
                STRAT_WORST: take = !r_found || (rd_data > r_best_sz);
                default:     take = 1'b0;
            endcase
        end
    end

    assign rd_addr = r_issue_cnt[IW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = in_idx32[IW-1:0];
        wr_data = amt48[SIZE_WIDTH-1:0];
        if (in_acc && i_opcode == OP_LOAD) begin
            wr_en = in_idx32 < BLOCKS;
        end else if (r_state == S_FIN && out_free && r_found) begin
            wr_en   = 1'b1;
            wr_addr = r_best_idx;
            wr_data = r_best_sz - SIZE_WIDTH'(r_need);
        end
    end

    fsba_ram #(
        .DEPTH (BLOCKS),
        .WIDTH (SIZE_WIDTH),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strategy    <= STRAT_FIRST;
            r_block_count <= BLOCK_COUNT_RST;
            r_issue_cnt   <= '0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_STRATEGY) begin
                    r_strategy <= i_cfg_wdata[STRAT_W-1:0];
                end else begin
                    r_block_count <= i_cfg_wdata;
                end
            end

            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_opcode == OP_REQUEST) begin
                        r_issue_cnt <= '0;
                        r_pend      <= 1'b0;
                        r_found     <= 1'b0;
                        r_state     <= (r_strategy == STRAT_FIRST || r_strategy == STRAT_BEST
                                        || r_strategy == STRAT_WORST) ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    if (r_issue_cnt < limit) begin
                        r_issue_cnt <= r_issue_cnt + 1'b1;
                        r_pend      <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_FIN;
                        end
                    end
                    if (take) begin
                        r_found <= 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_need <= i_amount;
            r_last <= i_last_request;
        end
        if (r_state == S_SCAN && r_issue_cnt < limit) begin
            r_pend_idx <= r_issue_cnt[IW-1:0];
        end
        if (take) begin
            r_best_idx <= r_pend_idx;
            r_best_sz  <= rd_data;
        end
        if (r_state == S_FIN && out_free) begin
            r_alloc    <= r_found;
            r_chosen   <= r_found ? best_idx32[INDEX_W-1:0] : '0;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_allocated    = r_alloc;
    assign o_chosen_block = r_chosen;
    assign o_last_result  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/core/fsba_ram.sv
// fsba_ram: single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module fsba_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire
